FILE: rtl/core/plt_pkg.sv
package plt_pkg;

	typedef enum logic [1:0] {
		CMD_REPORT = 2'd0,
		CMD_EOP    = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_NOT_RUNNING = 3'd0,
		ST_STARTING    = 3'd1,
		ST_RUNNING     = 3'd2,
		ST_SUSPENDED   = 3'd3,
		ST_EXITING     = 3'd4
	} lstate_t;

	// one stored entry (key, lifecycle data)
	typedef struct packed {
		logic [7:0]  grp;
		logic [31:0] pid;
		logic [63:0] start;
		logic [2:0]  st;
		logic [63:0] gen;
	} entry_t;

	// one result word
	typedef struct packed {
		logic [7:0]  grp;
		logic [31:0] pid;
		logic [2:0]  from_st;
		logic [2:0]  to_st;
		logic [63:0] gen;
		logic [63:0] start;
		logic        drop;
		logic        last;
	} result_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_DECIDE,
		FSM_EMIT,
		FSM_EMIT2
	} fsm_t;

endpackage

FILE: rtl/core/plt_table.sv
module plt_table #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic            clk,
	input  logic [AW-1:0]   rd_addr,
	output plt_pkg::entry_t rd_data,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  plt_pkg::entry_t wr_data
);
	import plt_pkg::*;

	entry_t mem_q [DEPTH];

	// synchronous single-port-write, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

FILE: rtl/core/plt_out_reg.sv
module plt_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  plt_pkg::result_t  push_data,
	output logic              full,
	output logic              valid,
	input  logic              stall,
	output plt_pkg::result_t  data
);
	import plt_pkg::*;

	result_t data_q;
	logic    valid_q;

	// single output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= push_data;
		end
	end

	assign full  = valid_q && stall;
	assign valid = valid_q;
	assign data  = data_q;

	// a stalled word stays valid and unchanged
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && stall |=> valid_q && $stable(data_q))
		else $error("output word changed under stall");
	// no new word lands on a stalled one
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into a full output register");
	assert property (@(posedge clk) disable iff (!arst_n)
		push |=> valid_q)
		else $error("pushed word not presented");

endmodule

FILE: rtl/core/presence_lifecycle_tracker_top.sv
// Flow: a report scans the whole table, then a decide step writes the hit or free slot;
// its first word is pushed from the emit state, the second word of a restart from emit2.
// End of poll: a table scan, longer while a stalled output blocks a word, then an emit.
// The input is stalled until a command is done, so a new one waits for the last to finish;
// clear, an unused command and a report with id 0 are taken in idle without a scan.
// Reset: empties the table at once through the valid/seen flops, generation back to one.
module presence_lifecycle_tracker_top #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        stall,
	input  logic [1:0]  command,
	input  logic [7:0]  group_id,
	input  logic [31:0] proc_id,
	input  logic [63:0] start_time,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  group_id_out,
	output logic [31:0] proc_id_out,
	output logic [2:0]  from_state,
	output logic [2:0]  to_state,
	output logic [63:0] generation_out,
	output logic [63:0] start_time_out,
	output logic        dropped,
	output logic        last
);
	import plt_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	fsm_t state_q, state_nx;

	logic [TABLE_DEPTH-1:0] vld_q, seen_q;
	logic [63:0]            ngen_q;
	logic [1:0]             cmd_q;
	logic [7:0]             grp_q;
	logic [31:0]            pid_q;
	logic [63:0]            t_q;
	logic [CW-1:0]          idx_q;
	logic                   hit_q, free_q;
	logic [AW-1:0]          hit_idx_q, free_idx_q;
	logic                   pend_q;     // read issued last cycle
	logic [AW-1:0]          pend_idx_q;
	result_t                r2_q;       // second word of a restart

	// any remaining unseen emitting slot? lookahead not possible, so last is
	// decided when the scan ends: hold one pending word until then
	result_t hold_q;
	logic    hold_v_q;

	entry_t  rd_data, wr_data;
	logic    wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	result_t push_data;
	logic    push, ofull;
	result_t odata;

	plt_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
		.clk(clk), .rd_addr(rd_addr), .rd_data(rd_data),
		.wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
	);

	plt_out_reg u_out (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data),
		.full(ofull), .valid(out_valid), .stall(out_stall), .data(odata)
	);

	assign group_id_out   = odata.grp;
	assign proc_id_out    = odata.pid;
	assign from_state     = odata.from_st;
	assign to_state       = odata.to_st;
	assign generation_out = odata.gen;
	assign start_time_out = odata.start;
	assign dropped        = odata.drop;
	assign last           = odata.last;

	assign stall = (state_q != FSM_IDLE);

	// scan sequencing: issue read at idx_q, evaluate pend_idx_q in the next cycle;
	// a stalled slot is read again, the scan end fetches the hit entry
	logic scan_done;
	logic scan_stall;
	logic eop_emit;
	logic [2:0] est;
	assign rd_addr   = scan_stall ? pend_idx_q
		: (idx_q == CW'(TABLE_DEPTH)) ? hit_idx_q : idx_q[AW-1:0];
	assign scan_done = (idx_q == CW'(TABLE_DEPTH)) && !pend_q;
	assign est       = rd_data.st;

	// end-of-poll evaluation of the slot just read
	logic eop_act, eop_unseen;
	assign eop_unseen = pend_q && vld_q[pend_idx_q] && !seen_q[pend_idx_q];
	assign eop_emit   = eop_unseen && (est == ST_STARTING || est == ST_RUNNING
		|| est == ST_SUSPENDED || est == ST_EXITING);
	assign eop_act    = (cmd_q == CMD_EOP) && state_q == FSM_SCAN;

	// restart decision on the hit entry
	logic restart;
	assign restart = (rd_data.start != 64'd0) && (t_q != 64'd0) && (rd_data.start != t_q);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (valid) begin
					if (command == CMD_REPORT && proc_id != 32'd0) state_nx = FSM_SCAN;
					else if (command == CMD_EOP) state_nx = FSM_SCAN;
				end
			end
			FSM_SCAN: begin
				if (eop_act && eop_emit && hold_v_q && ofull) state_nx = FSM_SCAN;
				else if (scan_done) state_nx = (cmd_q == CMD_EOP) ? FSM_EMIT : FSM_DECIDE;
			end
			FSM_DECIDE: state_nx = FSM_EMIT;
			FSM_EMIT: begin
				if (!ofull) state_nx = (hit_q && r2_q.last == 1'b0 && cmd_q == CMD_REPORT
					&& r2_q.to_st == ST_STARTING) ? FSM_EMIT2 : FSM_IDLE;
			end
			FSM_EMIT2: if (!ofull) state_nx = FSM_IDLE;
			default: state_nx = FSM_IDLE;
		endcase
	end

	// datapath outputs
	assign scan_stall = eop_act && eop_emit && hold_v_q && ofull;

	always_comb begin
		wr_en     = 1'b0;
		wr_addr   = pend_idx_q;
		wr_data   = rd_data;
		push      = 1'b0;
		push_data = hold_q;
		unique case (state_q)
			FSM_SCAN: begin
				if (eop_act && eop_emit && !scan_stall) begin
					if (est != ST_EXITING) begin
						wr_en      = 1'b1;
						wr_data.st = ST_EXITING;
					end
					push = hold_v_q;
				end
			end
			FSM_EMIT: begin
				if (cmd_q == CMD_EOP) begin
					push      = hold_v_q && !ofull;
					push_data = hold_q;
					push_data.last = 1'b1;
				end else if (!ofull) begin
					push      = hold_v_q;
					push_data = hold_q;
				end
			end
			FSM_EMIT2: begin
				push      = !ofull;
				push_data = r2_q;
				push_data.last = 1'b1;
			end
			FSM_DECIDE: begin
				wr_addr = hit_q ? hit_idx_q : free_idx_q;
				if (hit_q) begin
					wr_en = 1'b1;
					wr_data.start = t_q;
					wr_data.st    = restart ? ST_STARTING : ST_RUNNING;
					wr_data.gen   = restart ? ngen_q : rd_data.gen;
				end else if (free_q) begin
					wr_en = 1'b1;
					wr_data.grp   = grp_q;
					wr_data.pid   = pid_q;
					wr_data.start = t_q;
					wr_data.st    = ST_STARTING;
					wr_data.gen   = ngen_q;
				end
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= FSM_IDLE;
			vld_q    <= '0;
			seen_q   <= '0;
			ngen_q   <= 64'd1;
			idx_q    <= '0;
			pend_q   <= 1'b0;
			hold_v_q <= 1'b0;
			hit_q    <= 1'b0;
			free_q   <= 1'b0;
		end else begin
			state_q <= state_nx;
			unique case (state_q)
				FSM_IDLE: begin
					idx_q    <= '0;
					pend_q   <= 1'b0;
					hit_q    <= 1'b0;
					free_q   <= 1'b0;
					hold_v_q <= 1'b0;
					if (valid && command == CMD_CLEAR) begin
						vld_q  <= '0;
						seen_q <= '0;
						ngen_q <= 64'd1;
					end
				end
				FSM_SCAN: begin
					if (!scan_stall) begin
						pend_q <= (idx_q != CW'(TABLE_DEPTH));
						if (idx_q != CW'(TABLE_DEPTH)) idx_q <= idx_q + 1'b1;
						if (pend_q) begin
							if (cmd_q == CMD_REPORT) begin
								if (vld_q[pend_idx_q]) begin
									if (!hit_q && rd_data.grp == grp_q && rd_data.pid == pid_q) begin
										hit_q <= 1'b1;
									end
								end else if (!free_q) begin
									free_q <= 1'b1;
								end
							end else begin
								if (vld_q[pend_idx_q]) begin
									if (seen_q[pend_idx_q]) seen_q[pend_idx_q] <= 1'b0;
									else begin
										if (est == ST_EXITING || !eop_emit)
											vld_q[pend_idx_q] <= 1'b0;
										if (eop_emit) hold_v_q <= 1'b1;
									end
								end
							end
						end
					end
				end
				FSM_DECIDE: begin
					if (hit_q) begin
						seen_q[hit_idx_q] <= 1'b1;
						if (restart) ngen_q <= ngen_q + 64'd1;
						hold_v_q <= restart || (rd_data.st != ST_RUNNING);
					end else if (free_q) begin
						vld_q[free_idx_q]  <= 1'b1;
						seen_q[free_idx_q] <= 1'b1;
						ngen_q   <= ngen_q + 64'd1;
						hold_v_q <= 1'b1;
					end else begin
						hold_v_q <= 1'b1;
					end
				end
				FSM_EMIT, FSM_EMIT2: ;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (!scan_stall) pend_idx_q <= idx_q[AW-1:0];
		if (state_q == FSM_IDLE && valid) begin
			cmd_q <= command;
			grp_q <= group_id;
			pid_q <= proc_id;
			t_q   <= start_time;
			r2_q.last <= 1'b1;
		end
		if (state_q == FSM_SCAN && pend_q && !scan_stall) begin
			if (cmd_q == CMD_REPORT) begin
				if (vld_q[pend_idx_q] && !hit_q && rd_data.grp == grp_q
					&& rd_data.pid == pid_q) hit_idx_q <= pend_idx_q;
				if (!vld_q[pend_idx_q] && !free_q) free_idx_q <= pend_idx_q;
			end else if (eop_emit) begin
				hold_q.grp     <= rd_data.grp;
				hold_q.pid     <= rd_data.pid;
				hold_q.from_st <= est;
				hold_q.to_st   <= (est == ST_EXITING) ? ST_NOT_RUNNING : ST_EXITING;
				hold_q.gen     <= rd_data.gen;
				hold_q.start   <= rd_data.start;
				hold_q.drop    <= 1'b0;
				hold_q.last    <= 1'b0;
			end
		end
		if (state_q == FSM_SCAN && scan_done && cmd_q == CMD_REPORT && hit_q) begin
			hit_idx_q <= hit_idx_q;
		end
		if (state_q == FSM_DECIDE) begin
			hold_q.grp  <= grp_q;
			hold_q.pid  <= pid_q;
			if (hit_q) begin
				hold_q.drop <= 1'b0;
				if (restart) begin
					hold_q.from_st <= rd_data.st;
					hold_q.to_st   <= ST_EXITING;
					hold_q.gen     <= rd_data.gen;
					hold_q.start   <= rd_data.start;
					hold_q.last    <= 1'b0;
					r2_q.grp     <= grp_q;
					r2_q.pid     <= pid_q;
					r2_q.from_st <= ST_NOT_RUNNING;
					r2_q.to_st   <= ST_STARTING;
					r2_q.gen     <= ngen_q;
					r2_q.start   <= t_q;
					r2_q.drop    <= 1'b0;
					r2_q.last    <= 1'b0;
				end else begin
					hold_q.from_st <= rd_data.st;
					hold_q.to_st   <= ST_RUNNING;
					hold_q.gen     <= rd_data.gen;
					hold_q.start   <= t_q;
					hold_q.last    <= 1'b1;
				end
			end else if (free_q) begin
				hold_q.from_st <= ST_NOT_RUNNING;
				hold_q.to_st   <= ST_STARTING;
				hold_q.gen     <= ngen_q;
				hold_q.start   <= t_q;
				hold_q.drop    <= 1'b0;
				hold_q.last    <= 1'b1;
			end else begin
				hold_q.from_st <= ST_NOT_RUNNING;
				hold_q.to_st   <= ST_NOT_RUNNING;
				hold_q.gen     <= 64'd0;
				hold_q.start   <= t_q;
				hold_q.drop    <= 1'b1;
				hold_q.last    <= 1'b1;
			end
		end
		if (state_q == FSM_EMIT2 && !ofull) r2_q.last <= 1'b1;
	end

	// r2_q.last low marks a pending second restart word; the pushed copy carries last

	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !ofull || state_q == FSM_SCAN)
		else $error("push into a stalled output word");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FSM_IDLE && valid && command == CMD_CLEAR |=> ngen_q == 64'd1)
		else $error("clear did not restart generations");
	assert property (@(posedge clk) disable iff (!arst_n)
		ngen_q != 64'd0 || $past(ngen_q) == 64'hFFFF_FFFF_FFFF_FFFF)
		else $error("generation counter hit zero without wrap");

endmodule
